/* src/qlbp_pkg.sv */
package qlbp_pkg;

    localparam int MaxStates  = 64;
    localparam int MaxWindow  = 16;
    localparam int ValueWidth = 24;
    localparam int RowW       = $clog2(MaxStates);
    localparam int TableW     = 3 * ValueWidth;

    localparam logic [16:0] WAlpha = 17'd13107;
    localparam logic [16:0] WKeep  = 17'd52429;
    localparam logic [16:0] WGamma = 17'd64881;

    typedef enum logic [2:0] {
        CMD_INIT    = 3'd0,
        CMD_CHOOSE  = 3'd1,
        CMD_SUCCESS = 3'd2,
        CMD_TIMEOUT = 3'd3,
        CMD_COLL    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_DEC  = 2'd0,
        ACT_KEEP = 2'd1,
        ACT_INC  = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        REG_CW_LOW   = 2'd0,
        REG_CW_HIGH  = 2'd1,
        REG_WIN_LEN  = 2'd2,
        REG_MIN_SUCC = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_CUR,
        ST_RD_LO,
        ST_RD_HI,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE,
        ST_CH_RD,
        ST_CHOOSE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] rand_req;
    } req_t;

    typedef struct packed {
        logic [6:0] backoff_count;
        logic [1:0] action;
        logic [7:0] collision_count;
        logic       violation;
        logic [4:0] fail_count;
    } rsp_t;

    // Boundary entry value: -100 saturated into the value range.
    function automatic logic signed [ValueWidth-1:0] boundary_value();
        logic signed [63:0] b;
        logic signed [63:0] lo;
        b  = -64'sd100 * 64'sd65536;
        lo = -(64'sd1 <<< (ValueWidth - 1));
        if (b < lo)
        begin
            b = lo;
        end
        return b[ValueWidth-1:0];
    endfunction

    function automatic logic signed [ValueWidth-1:0] row_max(input logic [TableW-1:0] r);
        logic signed [ValueWidth-1:0] a0, a1, a2, m;
        a0 = r[ValueWidth-1:0];
        a1 = r[2*ValueWidth-1:ValueWidth];
        a2 = r[3*ValueWidth-1:2*ValueWidth];
        m = a0;
        if (a1 > m)
        begin
            m = a1;
        end
        if (a2 > m)
        begin
            m = a2;
        end
        return m;
    endfunction

endpackage

/* src/q_learning_backoff_policy_unit.sv */
// Adaptive backoff policy with a 64-row Q table held in one single-port-read RAM.
// A command is taken when start is high and busy is low; its result is on rsp
// while done is high for exactly one cycle and cannot be stalled. Unknown codes
// go straight to done; choose reads the current row and picks an action. Success,
// timeout and collision read the current row and both neighbour rows in turn
// through the one read port, then perform two registered multiply stages before
// writing back; a collision then also chooses. An init command, and reset itself,
// clears the table with one row a cycle; busy stays high until the reset clear ends.
module q_learning_backoff_policy_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qlbp_pkg::req_t     req,
    output logic               busy,
    output logic               done,
    output qlbp_pkg::rsp_t     rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qlbp_pkg::*;

    logic [6:0] lo_bound, hi_bound;
    logic [4:0] win_k, win_m;

    // Configuration registers.
    qlbp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .lo_bound (lo_bound),
        .hi_bound (hi_bound),
        .win_k    (win_k),
        .win_m    (win_m)
    );

    // Learning engine with its table memory.
    qlbp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp),
        .lo_bound (lo_bound),
        .hi_bound (hi_bound),
        .win_k    (win_k),
        .win_m    (win_m)
    );

endmodule

/* src/qlbp_ram.sv */
module qlbp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/qlbp_cfg.sv */
module qlbp_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [6:0]  lo_bound,
    output logic [6:0]  hi_bound,
    output logic [4:0]  win_k,
    output logic [4:0]  win_m
);
    import qlbp_pkg::*;

    logic [6:0] cw_low_reg, cw_high_reg;
    logic [4:0] win_len_reg, min_succ_reg;
    logic       wr_en;
    reg_idx_t   idx;
    logic [7:0] hi_cap;
    logic [4:0] k_tmp;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_low_reg   <= 7'd16;
            cw_high_reg  <= 7'd64;
            win_len_reg  <= 5'd10;
            min_succ_reg <= 5'd6;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CW_LOW:   cw_low_reg   <= pwdata[6:0];
                REG_CW_HIGH:  cw_high_reg  <= pwdata[6:0];
                REG_WIN_LEN:  win_len_reg  <= pwdata[4:0];
                REG_MIN_SUCC: min_succ_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (idx)
            REG_CW_LOW:   prdata = {25'd0, cw_low_reg};
            REG_CW_HIGH:  prdata = {25'd0, cw_high_reg};
            REG_WIN_LEN:  prdata = {27'd0, win_len_reg};
            REG_MIN_SUCC: prdata = {27'd0, min_succ_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Effective bounds and window limits.
    always_comb
    begin
        lo_bound = (cw_low_reg == 7'd0) ? 7'd1 : cw_low_reg;
        hi_bound = (cw_high_reg < lo_bound) ? lo_bound : cw_high_reg;
        hi_cap   = {1'b0, lo_bound} + 8'(MaxStates - 1);
        if ({1'b0, hi_bound} > hi_cap)
        begin
            hi_bound = hi_cap[6:0];
        end
        k_tmp = (win_len_reg == 5'd0) ? 5'd1 : win_len_reg;
        win_k = (k_tmp > 5'(MaxWindow)) ? 5'(MaxWindow) : k_tmp;
        win_m = (min_succ_reg > win_k) ? win_k : min_succ_reg;
    end

endmodule

/* src/qlbp_core.sv */
module qlbp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qlbp_pkg::req_t     req,
    output logic               busy,
    output logic               done,
    output qlbp_pkg::rsp_t     rsp,
    input  logic [6:0]         lo_bound,
    input  logic [6:0]         hi_bound,
    input  logic [4:0]         win_k,
    input  logic [4:0]         win_m
);
    import qlbp_pkg::*;

    localparam int ProdW = ValueWidth + 18;

    state_t state_reg, state_next;

    logic [6:0]  count_reg;
    logic [1:0]  act_reg;
    logic [7:0]  coll_reg;
    logic [MaxWindow-1:0] win_reg;
    logic        viol_reg;
    logic [2:0]  cmd_reg;
    logic [7:0]  rand_reg;
    logic        clr_busy_reg;
    logic [RowW-1:0] clr_reg;

    logic [RowW-1:0] row_reg;
    logic        has_lo_reg, has_hi_reg;
    logic [TableW-1:0] cur_reg;
    logic signed [ValueWidth-1:0] best_reg;
    logic signed [ProdW-1:0] d_reg;
    logic signed [ProdW+1:0] acc_reg;
    logic signed [ValueWidth-1:0] new_v;

    logic              we;
    logic [RowW-1:0]   waddr, raddr;
    logic [TableW-1:0] wdata, rdata;

    logic [6:0]  cnt_cl;
    logic [7:0]  row_w;
    logic [7:0]  last_row;

    qlbp_ram #(.Width(TableW), .Depth(MaxStates)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Count clamped into the current bounds.
    always_comb
    begin
        cnt_cl = count_reg;
        if (cnt_cl < lo_bound)
        begin
            cnt_cl = lo_bound;
        end
        if (cnt_cl > hi_bound)
        begin
            cnt_cl = hi_bound;
        end
        row_w    = {1'b0, cnt_cl} - {1'b0, lo_bound};
        last_row = {1'b0, hi_bound} - {1'b0, lo_bound};
    end

    // Failures among the newest k outcomes.
    function automatic logic [4:0] fails(input logic [MaxWindow-1:0] w, input logic [4:0] k);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < MaxWindow; i++)
        begin
            if (5'(i) < k && !w[i])
            begin
                n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // Remainder by three: base-four digits are summed, then reduced by compare and subtract.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        if (s >= 4'd6)
        begin
            s = s - 4'd6;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

    // Update arithmetic.
    logic signed [ProdW-1:0] gprod;
    logic signed [ProdW-1:0] d_rnd;
    logic signed [ProdW+1:0] tval;
    logic signed [ValueWidth-1:0] old_v;
    logic signed [ProdW+1:0] acc_rnd;
    logic signed [ProdW+1:0] sat_hi, sat_lo;
    logic signed [ValueWidth-1:0] row_best;

    assign gprod  = ProdW'(best_reg) * $signed({1'b0, WGamma});
    assign d_rnd  = (d_reg + ProdW'(32768)) >>> 16;
    assign tval   = (ProdW+2)'(d_rnd)
                  + ((cmd_reg == CMD_SUCCESS) ? (ProdW+2)'(65536) : -(ProdW+2)'(65536));
    assign old_v  = cur_reg[act_reg*ValueWidth +: ValueWidth];
    assign acc_rnd = (acc_reg + (ProdW+2)'(32768)) >>> 16;
    assign sat_hi = (ProdW+2)'((64'sd1 <<< (ValueWidth - 1)) - 1);
    assign sat_lo = -sat_hi - 1;
    assign row_best = row_max(rdata);

    // Saturate the rounded update into the value range.
    always_comb
    begin
        if (acc_rnd > sat_hi)
        begin
            new_v = sat_hi[ValueWidth-1:0];
        end
        else if (acc_rnd < sat_lo)
        begin
            new_v = sat_lo[ValueWidth-1:0];
        end
        else
        begin
            new_v = acc_rnd[ValueWidth-1:0];
        end
    end

    // Choice among tied maxima.
    logic [1:0] ch_act;
    always_comb
    begin
        logic signed [ValueWidth-1:0] m;
        logic [1:0] n;
        logic [1:0] t0, t1, t2;
        logic [1:0] pick;
        m = row_max(cur_reg);
        n = 2'd0;
        t0 = ACT_KEEP;
        t1 = ACT_KEEP;
        t2 = ACT_KEEP;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(cur_reg[a*ValueWidth +: ValueWidth]) == m)
            begin
                case (n)
                    2'd0:    t0 = 2'(a);
                    2'd1:    t1 = 2'(a);
                    default: t2 = 2'(a);
                endcase
                n = n + 2'd1;
            end
        end
        case (n)
            2'd1:    pick = 2'd0;
            2'd2:    pick = {1'b0, rand_reg[0]};
            default: pick = mod3(rand_reg);
        endcase
        case (pick)
            2'd0:    ch_act = t0;
            2'd1:    ch_act = t1;
            default: ch_act = t2;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_busy_reg)
                begin
                    state_next = ST_CLEAR;
                end
                else if (start)
                begin
                    case (req.cmd)
                        CMD_INIT:                 state_next = ST_CLEAR;
                        CMD_CHOOSE:               state_next = ST_CH_RD;
                        CMD_SUCCESS, CMD_TIMEOUT,
                        CMD_COLL:                 state_next = ST_RD_CUR;
                        default:                  state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:  state_next = (clr_reg == RowW'(MaxStates - 1))
                                    ? (clr_busy_reg ? ST_IDLE : ST_DONE) : ST_CLEAR;
            ST_RD_CUR: state_next = ST_RD_LO;
            ST_RD_LO:  state_next = ST_RD_HI;
            ST_RD_HI:  state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_WRITE;
            ST_WRITE:  state_next = (cmd_reg == CMD_COLL) ? ST_CH_RD : ST_DONE;
            ST_CH_RD:  state_next = ST_CHOOSE;
            ST_CHOOSE: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = row_reg;
        wdata = cur_reg;
        raddr = row_reg;
        case (state_reg)
            ST_IDLE:   raddr = row_w[RowW-1:0];
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '0;
                if (clr_reg == '0)
                begin
                    wdata[ValueWidth-1:0] = boundary_value();
                end
                if ({1'b0, last_row} == {1'b0, 8'(clr_reg)})
                begin
                    wdata[3*ValueWidth-1:2*ValueWidth] = boundary_value();
                end
            end
            ST_RD_CUR: raddr = row_reg - RowW'(1);
            ST_RD_LO:  raddr = row_reg + RowW'(1);
            ST_WRITE:
            begin
                we = 1'b1;
                wdata[act_reg*ValueWidth +: ValueWidth] = new_v;
            end
            default: ;
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy = (state_reg != ST_IDLE) || clr_busy_reg;
        done = (state_reg == ST_DONE);
        rsp.backoff_count   = count_reg;
        rsp.action          = act_reg;
        rsp.collision_count = coll_reg;
        rsp.violation       = viol_reg;
        rsp.fail_count      = fails(win_reg, win_k);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clr_busy_reg <= 1'b1;
            clr_reg      <= '0;
            count_reg    <= 7'd16;
            act_reg      <= ACT_KEEP;
            coll_reg     <= 8'd0;
            win_reg      <= '1;
            viol_reg     <= 1'b0;
            cmd_reg      <= CMD_INIT;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    clr_reg <= '0;
                    if (!clr_busy_reg && start)
                    begin
                        cmd_reg  <= req.cmd;
                        rand_reg <= req.rand_req;
                        viol_reg <= 1'b0;
                        row_reg  <= row_w[RowW-1:0];
                        has_lo_reg <= (row_w != 8'd0);
                        has_hi_reg <= (row_w < last_row) && (row_w < 8'(MaxStates - 1));
                        if (req.cmd inside {CMD_CHOOSE, CMD_SUCCESS, CMD_TIMEOUT, CMD_COLL})
                        begin
                            count_reg <= cnt_cl;
                        end
                        case (req.cmd)
                            CMD_INIT:
                            begin
                                count_reg <= lo_bound;
                                act_reg   <= ACT_KEEP;
                                coll_reg  <= 8'd0;
                                win_reg   <= '1;
                            end
                            CMD_CHOOSE:  coll_reg <= 8'd0;
                            CMD_SUCCESS: win_reg  <= {win_reg[MaxWindow-2:0], 1'b1};
                            CMD_TIMEOUT: win_reg  <= {win_reg[MaxWindow-2:0], 1'b0};
                            CMD_COLL:
                            begin
                                win_reg <= {win_reg[MaxWindow-2:0], 1'b0};
                                if (coll_reg != 8'd255)
                                begin
                                    coll_reg <= coll_reg + 8'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + RowW'(1);
                    if (clr_reg == RowW'(MaxStates - 1))
                    begin
                        clr_busy_reg <= 1'b0;
                    end
                end
                ST_RD_CUR:
                begin
                    cur_reg  <= rdata;
                    best_reg <= row_best;
                end
                ST_RD_LO:
                begin
                    if (has_lo_reg && row_best > best_reg)
                    begin
                        best_reg <= row_best;
                    end
                end
                ST_RD_HI:
                begin
                    if (has_hi_reg && row_best > best_reg)
                    begin
                        best_reg <= row_best;
                    end
                    if (cmd_reg != CMD_SUCCESS && fails(win_reg, win_k) > (win_k - win_m))
                    begin
                        viol_reg <= 1'b1;
                        win_reg  <= '1;
                    end
                end
                ST_MUL1:
                begin
                    d_reg <= gprod;
                end
                ST_MUL2:
                begin
                    acc_reg <= (ProdW+2)'(old_v) * $signed({1'b0, WKeep})
                             + tval * $signed({1'b0, WAlpha});
                end
                ST_WRITE:
                begin
                    // Keep the local row copy in step with the entry being written.
                    cur_reg[act_reg*ValueWidth +: ValueWidth] <= new_v;
                end
                ST_CH_RD:
                begin
                    // After a collision the local copy already holds the updated row;
                    // the read issued during the write would return the old entry.
                    if (cmd_reg != CMD_COLL)
                    begin
                        cur_reg <= rdata;
                    end
                end
                ST_CHOOSE:
                begin
                    act_reg <= ch_act;
                    if (ch_act == ACT_DEC && count_reg > lo_bound)
                    begin
                        count_reg <= count_reg - 7'd1;
                    end
                    else if (ch_act == ACT_INC && count_reg < hi_bound)
                    begin
                        count_reg <= count_reg + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* verif/tb_q_learning_backoff_policy_unit.sv */
module tb_q_learning_backoff_policy_unit;
    import qlbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int MaxReported   = 10;

    typedef struct {
        logic [2:0] cmd;
        logic [7:0] rand_req;
        bit         typed;
        rsp_t       rsp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    req_t        req;
    logic        busy;
    logic        done;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and its copy of the configuration registers.
    logic [6:0]  cfg_cw_low;
    logic [6:0]  cfg_cw_high;
    logic [4:0]  cfg_win_len;
    logic [4:0]  cfg_min_succ;
    int unsigned pol_count;
    int unsigned pol_action;
    int unsigned pol_coll;
    logic [15:0] pol_window;
    longint      q_value [MaxStates][3];

    rsp_t        expected_words [$];
    int          mismatches;
    int          words_seen;
    int          items_sent;
    int          idle_cycles;
    stim_row_t   directed [$];

    q_learning_backoff_policy_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint sat_q(input longint v);
        longint hi;
        hi = (longint'(1) <<< (ValueWidth - 1)) - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < -hi - 1)
        begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic longint round_q16(input longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic int unsigned lo_bound();
        return (cfg_cw_low == 0) ? 1 : int'(cfg_cw_low);
    endfunction

    function automatic int unsigned hi_bound();
        int unsigned lo;
        int unsigned hi;
        lo = lo_bound();
        hi = (cfg_cw_high < lo) ? lo : int'(cfg_cw_high);
        if (hi - lo >= MaxStates)
        begin
            hi = lo + MaxStates - 1;
        end
        return hi;
    endfunction

    function automatic int unsigned window_k();
        int unsigned k;
        k = (cfg_win_len == 0) ? 1 : int'(cfg_win_len);
        if (k > MaxWindow)
        begin
            k = MaxWindow;
        end
        return k;
    endfunction

    function automatic int unsigned count_fails();
        int unsigned k;
        int unsigned ones;
        k = window_k();
        ones = 0;
        for (int i = 0; i < k; i++)
        begin
            ones += pol_window[i];
        end
        return k - ones;
    endfunction

    function automatic longint best_in_row(input int unsigned r);
        longint m;
        m = q_value[r][0];
        if (q_value[r][1] > m) m = q_value[r][1];
        if (q_value[r][2] > m) m = q_value[r][2];
        return m;
    endfunction

    task automatic clear_values();
        int unsigned last;
        last = hi_bound() - lo_bound();
        for (int r = 0; r < MaxStates; r++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                q_value[r][a] = 0;
            end
        end
        q_value[0][ACT_DEC] = sat_q(-100 * 65536);
        q_value[last][ACT_INC] = sat_q(-100 * 65536);
    endtask

    task automatic update_value(input longint reward);
        int unsigned lo;
        int unsigned r;
        int unsigned nrows;
        int unsigned a;
        longint best;
        longint t;
        lo = lo_bound();
        r = (pol_count - lo) % MaxStates;
        nrows = hi_bound() - lo + 1;
        a = (pol_action > 2) ? ACT_KEEP : pol_action;
        best = best_in_row(r);
        if (r > 0 && best_in_row(r - 1) > best)
        begin
            best = best_in_row(r - 1);
        end
        if (r + 1 < nrows && r + 1 < MaxStates && best_in_row(r + 1) > best)
        begin
            best = best_in_row(r + 1);
        end
        t = reward + round_q16(longint'(WGamma) * best);
        q_value[r][a] = sat_q(round_q16(longint'(WKeep) * q_value[r][a]
                                        + longint'(WAlpha) * t));
    endtask

    task automatic choose_step(input logic [7:0] rnd);
        int unsigned lo;
        int unsigned r;
        int unsigned ties [3];
        int unsigned n;
        longint m;
        lo = lo_bound();
        r = (pol_count - lo) % MaxStates;
        m = best_in_row(r);
        n = 0;
        for (int a = 0; a < 3; a++)
        begin
            if (q_value[r][a] == m)
            begin
                ties[n] = a;
                n++;
            end
        end
        pol_action = ties[rnd % n];
        if (pol_action == ACT_DEC && pol_count > lo)
        begin
            pol_count--;
        end
        else if (pol_action == ACT_INC && pol_count < hi_bound())
        begin
            pol_count++;
        end
    endtask

    task automatic timeout_step(output bit viol);
        int unsigned k;
        int unsigned m;
        pol_window = pol_window << 1;
        update_value(-65536);
        k = window_k();
        m = (cfg_min_succ > k) ? k : int'(cfg_min_succ);
        viol = 0;
        if (count_fails() > k - m)
        begin
            pol_window = '1;
            viol = 1;
        end
    endtask

    // Advance the policy model by one command word and give its response.
    task automatic predict_policy(input logic [2:0] cmd, input logic [7:0] rnd,
                                  output rsp_t res);
        bit viol;
        viol = 0;
        if (cmd >= CMD_CHOOSE && cmd <= CMD_COLL)
        begin
            if (pol_count < lo_bound()) pol_count = lo_bound();
            if (pol_count > hi_bound()) pol_count = hi_bound();
        end
        case (cmd)
            CMD_INIT:
            begin
                clear_values();
                pol_count = lo_bound();
                pol_action = ACT_KEEP;
                pol_coll = 0;
                pol_window = '1;
            end
            CMD_CHOOSE:
            begin
                pol_coll = 0;
                choose_step(rnd);
            end
            CMD_SUCCESS:
            begin
                pol_window = (pol_window << 1) | 16'd1;
                update_value(65536);
            end
            CMD_TIMEOUT:
            begin
                timeout_step(viol);
            end
            CMD_COLL:
            begin
                if (pol_coll < 255) pol_coll++;
                timeout_step(viol);
                choose_step(rnd);
            end
            default:
            begin
            end
        endcase
        res.backoff_count   = pol_count[6:0];
        res.action          = pol_action[1:0];
        res.collision_count = pol_coll[7:0];
        res.violation       = viol;
        res.fail_count      = count_fails();
    endtask

    // Register write over the APB port; only called while the block is idle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CW_LOW:   cfg_cw_low   = value[6:0];
            REG_CW_HIGH:  cfg_cw_high  = value[6:0];
            REG_WIN_LEN:  cfg_win_len  = value[4:0];
            default:      cfg_min_succ = value[4:0];
        endcase
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic drain_words();
        start <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(input int lo, input int hi, input int k, input int m);
        drain_words();
        write_reg(REG_CW_LOW, lo);
        write_reg(REG_CW_HIGH, hi);
        write_reg(REG_WIN_LEN, k);
        write_reg(REG_MIN_SUCC, m);
    endtask

    // Issue one command word and return at its accepting edge, start left high.
    // A typed row also checks the predictor against its fixed value.
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] rnd,
                             input bit typed, input rsp_t fixed);
        rsp_t res;
        start <= 1'b1;
        req   <= '{cmd: cmd, rand_req: rnd};
        @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        predict_policy(cmd, rnd, res);
        if (typed && res != fixed)
        begin
            mismatches++;
            if (mismatches <= MaxReported)
                $display("directed row mismatch: table %h predictor %h", fixed, res);
        end
        expected_words.insert(expected_words.size(), res);
        items_sent++;
    endtask

    // Weighted random command: mostly valid MAC events, sometimes init or junk.
    function automatic logic [2:0] pick_cmd();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 2) return CMD_INIT;
        if (p < 4) return 3'($urandom_range(7, 5));
        if (p < 30) return CMD_CHOOSE;
        if (p < 55) return CMD_SUCCESS;
        if (p < 80) return CMD_TIMEOUT;
        return CMD_COLL;
    endfunction

    // Compare each response word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MaxReported)
                    $display("unexpected response word %p", rsp);
            end
            else
            begin
                rsp_t exp_w;
                exp_w = expected_words[0];
                expected_words.delete(0);
                if (rsp.backoff_count !== exp_w.backoff_count ||
                    rsp.action !== exp_w.action ||
                    rsp.collision_count !== exp_w.collision_count ||
                    rsp.violation !== exp_w.violation ||
                    rsp.fail_count !== exp_w.fail_count)
                begin
                    mismatches++;
                    if (mismatches <= MaxReported)
                        $display("response mismatch: expected %p got %p", exp_w, rsp);
                end
            end
        end
    end

    // Watchdog on cycles with no word moving in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rsp_t z;
        int burst;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        words_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        cfg_cw_low = 16;
        cfg_cw_high = 64;
        cfg_win_len = 10;
        cfg_min_succ = 6;
        pol_count = 16;
        pol_action = ACT_KEEP;
        pol_coll = 0;
        pol_window = '1;
        clear_values();
        z = '0;

        // Directed rows: fixed values where the outcome is plain.
        directed.push_back('{CMD_CHOOSE, 8'd0, 1, '{7'd16, ACT_KEEP, 8'd0, 1'b0, 5'd0}});
        directed.push_back('{3'd7, 8'hFF, 1, '{7'd16, ACT_KEEP, 8'd0, 1'b0, 5'd0}});
        directed.push_back('{3'd5, 8'h00, 0, z});
        directed.push_back('{3'd6, 8'hAA, 0, z});
        directed.push_back('{CMD_SUCCESS, 8'h55, 0, z});
        for (int i = 0; i < 5; i++)
            directed.push_back('{CMD_TIMEOUT, 8'(i), 0, z});
        directed.push_back('{CMD_COLL, 8'hFF, 0, z});
        directed.push_back('{CMD_COLL, 8'h80, 0, z});
        directed.push_back('{CMD_CHOOSE, 8'h7F, 0, z});
        directed.push_back('{CMD_CHOOSE, 8'h01, 0, z});
        directed.push_back('{CMD_SUCCESS, 8'h02, 0, z});
        directed.push_back('{CMD_INIT, 8'hFF, 1, '{7'd16, ACT_KEEP, 8'd0, 1'b0, 5'd0}});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i].cmd, directed[i].rand_req, directed[i].typed,
                      directed[i].rsp);

        // Out-of-range bounds and window, then the extremes.
        set_config(0, 0, 0, 31);
        send_word(CMD_INIT, 8'h00, 1, '{7'd1, ACT_KEEP, 8'd0, 1'b0, 5'd0});
        send_word(CMD_TIMEOUT, 8'h00, 1, '{7'd1, ACT_KEEP, 8'd0, 1'b1, 5'd0});
        set_config(127, 10, 31, 0);
        send_word(CMD_CHOOSE, 8'h03, 0, z);
        send_word(CMD_TIMEOUT, 8'h03, 0, z);
        set_config(1, 127, 16, 16);
        send_word(CMD_INIT, 8'h00, 0, z);
        send_word(CMD_COLL, 8'h00, 0, z);

        // Random phases across a range of settings.
        for (int phase = 0; phase < 13; phase++)
        begin
            case (phase % 4)
                0: set_config(1, 64, 16, 0);
                1: set_config($urandom_range(127), $urandom_range(127),
                              $urandom_range(31), $urandom_range(31));
                2: set_config(64, 1, 1, 16);
                default: set_config($urandom_range(1, 40), $urandom_range(20, 64),
                                    $urandom_range(1, 16), $urandom_range(0, 16));
            endcase
            if ($urandom_range(1)) send_word(CMD_INIT, 8'($urandom), 0, z);
            for (int n = 0; n < 150; )
            begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 150; b++, n++)
                    send_word(pick_cmd(), 8'($urandom), 0, z);
                if ($urandom_range(9) == 0)
                    drain_words();
                else
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end

        drain_words();
        $display("Ran %0d command words over 16 register settings, %0d responses checked.",
                 items_sent, words_seen);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
